FILE: rtl/core/ocls_pkg.sv
package ocls_pkg;

    localparam int ANGLE_BINS_DEF = 181;

    // Fixed field widths.
    localparam int NUM_W  = 26;   // magnitude of a projection numerator
    localparam int DEN_W  = 13;   // accepted depth
    localparam int PROJ_W = 28;   // signed projection numerator and pixel
    localparam int DIST_W = 35;   // signed plane distance in mm Q.14
    localparam int ACC_W  = 25;   // signed bearing accumulator, 2^-16 degree
    localparam int ROT_W  = 35;   // signed rotation vector components
    localparam int CORDIC_STEPS = 16;

    localparam logic [PROJ_W-1:0] FOCAL    = PROJ_W'(925);
    localparam logic [PROJ_W-1:0] CENTER_U = PROJ_W'(640);
    localparam logic [PROJ_W-1:0] CENTER_V = PROJ_W'(360);

    localparam logic signed [DIST_W-1:0] OBST_TH   = DIST_W'(100 * 16384);
    localparam logic signed [DIST_W-1:0] YELLOW_TH = DIST_W'(50 * 16384);
    localparam logic signed [DIST_W-1:0] GROUND_TH = DIST_W'(20 * 16384);

    localparam logic signed [ACC_W-1:0] ANGLE_MAX = ACC_W'(90 * 65536);

    // Point classes.
    localparam logic [2:0] CLS_NONE   = 3'd0;
    localparam logic [2:0] CLS_OBST   = 3'd1;
    localparam logic [2:0] CLS_GRAY   = 3'd2;
    localparam logic [2:0] CLS_YELLOW = 3'd3;
    localparam logic [2:0] CLS_GROUND = 3'd4;

    // Configuration register indexes.
    localparam logic [3:0] REG_PLANE_A  = 4'd0;
    localparam logic [3:0] REG_PLANE_B  = 4'd1;
    localparam logic [3:0] REG_PLANE_C  = 4'd2;
    localparam logic [3:0] REG_OFFSET   = 4'd3;
    localparam logic [3:0] REG_DEPTH_LO = 4'd4;
    localparam logic [3:0] REG_DEPTH_HI = 4'd5;
    localparam logic [3:0] REG_WIDTH    = 4'd6;
    localparam logic [3:0] REG_HEIGHT   = 4'd7;

    // Arctangent of 2^-i in units of 2^-16 degree.
    function automatic logic [21:0] atan_q16(input logic [3:0] i);
        logic [21:0] r;
        case (i)
            4'd0:  r = 22'd2949120;
            4'd1:  r = 22'd1740967;
            4'd2:  r = 22'd919879;
            4'd3:  r = 22'd466945;
            4'd4:  r = 22'd234379;
            4'd5:  r = 22'd117304;
            4'd6:  r = 22'd58666;
            4'd7:  r = 22'd29335;
            4'd8:  r = 22'd14668;
            4'd9:  r = 22'd7334;
            4'd10: r = 22'd3667;
            4'd11: r = 22'd1833;
            4'd12: r = 22'd917;
            4'd13: r = 22'd458;
            4'd14: r = 22'd229;
            4'd15: r = 22'd115;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/ocls_ram.sv
module ocls_ram #(
    parameter int W     = 13,
    parameter int DEPTH = 181,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/ocls_div.sv
module ocls_div
    import ocls_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo,
    output logic             o_rem_nz
);
    // Restoring division, one quotient bit per cycle.
    logic             r_busy;
    logic             r_done;
    logic [4:0]       r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   rem_sh;
    logic             ge;

    assign rem_sh = {r_rem, r_q[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= ge ? DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DEN_W-1:0];
                r_q   <= {r_q[NUM_W-2:0], ge};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_quo    = r_q;
    assign o_rem_nz = |r_rem;
endmodule

FILE: rtl/core/ocls_cordic.sv
module ocls_cordic
    import ocls_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [12:0] i_z,
    input  logic [15:0] i_ax,
    output logic        o_done,
    output logic [6:0]  o_deg
);
    // Vectoring rotation, one step per cycle, angle accumulated in 2^-16 degree.
    logic                    r_busy;
    logic                    r_done;
    logic [3:0]              r_i;
    logic signed [ROT_W-1:0] r_cx;
    logic signed [ROT_W-1:0] r_cy;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ROT_W-1:0] cy_neg;
    logic signed [ACC_W-1:0] step_ang;
    logic signed [ACC_W-1:0] clamped;
    logic [ACC_W-1:0]        rounded;

    assign cy_neg   = -r_cy;
    assign step_ang = $signed(ACC_W'(atan_q16(r_i)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_cx   <= $signed({8'd0, i_z, 14'd0});
                r_cy   <= $signed({5'd0, i_ax, 14'd0});
                r_acc  <= '0;
            end else if (r_busy) begin
                if (!r_cy[ROT_W-1]) begin
                    r_cx  <= r_cx + (r_cy >>> r_i);
                    r_cy  <= r_cy - (r_cx >>> r_i);
                    r_acc <= r_acc + step_ang;
                end else begin
                    r_cx  <= r_cx + (cy_neg >>> r_i);
                    r_cy  <= r_cy + (r_cx >>> r_i);
                    r_acc <= r_acc - step_ang;
                end
                r_i <= r_i + 4'd1;
                if (r_i == 4'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_acc < 0) begin
            clamped = '0;
        end else if (r_acc > ANGLE_MAX) begin
            clamped = ANGLE_MAX;
        end else begin
            clamped = r_acc;
        end
        rounded = ACC_W'($unsigned(clamped) + ACC_W'(32768));
    end

    assign o_done = r_done;
    assign o_deg  = rounded[22:16];
endmodule

FILE: rtl/core/plane_obstacle_point_classifier.sv
// Ground-plane obstacle point classifier with a per-degree nearest-depth scan.
//
// Input channel (i_valid / o_ready): one word per item. With i_cmd low the word
// is a camera point in millimetres; with i_cmd high it reads and clears the
// degree bin named by i_bin_angle. Output channel (o_valid / i_ready): exactly
// one result word per input word, in order.
// Configuration channel (i_cfg_valid / o_cfg_ready): always ready; write
// register i_cfg_index with i_cfg_data only while no item is in flight.
//
// The block works on one item at a time. A read command checks the bin index
// and reads the bin store before its result is registered. A dropped point goes
// straight to its result; otherwise the two projection divisions run one
// quotient bit per cycle, and obstacle points add the bearing rotation and its
// handoff plus a read-modify-write of the bin store.
// The block takes its next word as soon as the result sits in the output
// register, so a stalled receiver holds back at most one further result, which
// waits in the final state until the output register is free.
// Reset clears all occupied flags and loads the register defaults; the depth
// store itself is not cleared, since an entry is only read under its flag.
module plane_obstacle_point_classifier
    import ocls_pkg::*;
#(
    parameter int ANGLE_BINS = ANGLE_BINS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_cmd,
    input  logic               i_point_valid,
    input  logic signed [15:0] i_point_x,
    input  logic signed [15:0] i_point_y,
    input  logic signed [15:0] i_point_z,
    input  logic signed [7:0]  i_bin_angle,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_pixel_in_view,
    output logic [11:0]        o_pixel_u,
    output logic [11:0]        o_pixel_v,
    output logic [2:0]         o_point_class,
    output logic signed [7:0]  o_obstacle_angle,
    output logic               o_bin_occupied,
    output logic [12:0]        o_bin_min_depth,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    localparam int AW = (ANGLE_BINS > 1) ? $clog2(ANGLE_BINS) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_DSTRT = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_CLS   = 4'd4;
    localparam logic [3:0] S_COR   = 4'd5;
    localparam logic [3:0] S_WRD   = 4'd6;
    localparam logic [3:0] S_WCMP  = 4'd7;
    localparam logic [3:0] S_RCHK  = 4'd8;
    localparam logic [3:0] S_RRD   = 4'd9;
    localparam logic [3:0] S_ROUT  = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    // Configuration registers.
    logic signed [15:0] r_plane_a, r_plane_b, r_plane_c, r_plane_offset;
    logic [12:0]        r_depth_min, r_depth_max;
    logic [11:0]        r_image_width, r_image_height;

    logic [3:0]  r_state;
    logic        r_pv;
    logic signed [15:0] r_x, r_y, r_z;
    logic signed [7:0]  r_bang;
    logic signed [PROJ_W-1:0] r_nu, r_nv;
    logic signed [DIST_W-1:0] r_dist;
    logic [2:0]  r_mcnt;
    logic [AW-1:0] r_idx;
    logic [ANGLE_BINS-1:0] r_flags;

    // Result under construction.
    logic        r_res_view;
    logic [11:0] r_res_u, r_res_v;
    logic [2:0]  r_res_cls;
    logic signed [7:0] r_res_ang;
    logic        r_res_occ;
    logic [12:0] r_res_min;

    // Output register.
    logic        r_o_valid;
    logic        r_o_view;
    logic [11:0] r_o_u, r_o_v;
    logic [2:0]  r_o_cls;
    logic signed [7:0] r_o_ang;
    logic        r_o_occ;
    logic [12:0] r_o_min;

    // Datapath helpers.
    logic               accept;
    logic               load_out;
    logic               drop;
    logic signed [PROJ_W-1:0] x_ext, y_ext, z_ext;
    logic signed [PROJ_W-1:0] nu_c, nv_c;
    logic signed [31:0] prod;
    logic signed [DIST_W-1:0] addend;
    logic               du_done, dv_done;
    logic [NUM_W-1:0]   qu, qv;
    logic               ru_nz, rv_nz;
    logic signed [PROJ_W-1:0] pix_u, pix_v;
    logic               in_view;
    logic [2:0]         cls_c;
    logic               cor_done;
    logic [6:0]         cor_deg;
    logic signed [7:0]  ang_c;
    logic signed [10:0] bidx_r, bidx_p;
    logic               bidx_r_ok, bidx_p_ok;
    logic               ram_we;
    logic [12:0]        ram_rdata;
    logic [15:0]        ax;

    assign accept      = i_valid && o_ready;
    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    // The finished result moves into the output register once that is free.
    assign load_out = (r_state == S_FIN) && (!r_o_valid || i_ready);

    assign x_ext = PROJ_W'(r_x);
    assign y_ext = PROJ_W'(r_y);
    assign z_ext = PROJ_W'(r_z);
    assign nu_c  = x_ext * $signed(FOCAL) + z_ext * $signed(CENTER_U);
    assign nv_c  = y_ext * $signed(FOCAL) + z_ext * $signed(CENTER_V);

    assign drop = !r_pv || (r_z < $signed({3'd0, r_depth_min}))
                  || (r_z > $signed({3'd0, r_depth_max})) || (r_z <= 16'sd0);

    // One plane product per cycle, accumulated with the plane offset into the distance.
    always_comb begin
        case (r_mcnt)
            3'd0:    prod = r_plane_a * r_x;
            3'd1:    prod = r_plane_b * r_y;
            3'd2:    prod = r_plane_c * r_z;
            default: prod = '0;
        endcase
        if (r_mcnt == 3'd3) begin
            addend = $signed({{5{r_plane_offset[15]}}, r_plane_offset, 14'd0});
        end else begin
            addend = DIST_W'(prod);
        end
    end

    ocls_div u_div_u (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_DSTRT),
        .i_num    (NUM_W'(r_nu[PROJ_W-1] ? -r_nu : r_nu)),
        .i_den    (r_z[12:0]),
        .o_done   (du_done),
        .o_quo    (qu),
        .o_rem_nz (ru_nz)
    );

    ocls_div u_div_v (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_DSTRT),
        .i_num    (NUM_W'(r_nv[PROJ_W-1] ? -r_nv : r_nv)),
        .i_den    (r_z[12:0]),
        .o_done   (dv_done),
        .o_quo    (qv),
        .o_rem_nz (rv_nz)
    );

    // Floor division: a negative numerator rounds away from zero.
    assign pix_u = r_nu[PROJ_W-1] ? -$signed({2'b00, qu} + PROJ_W'(ru_nz))
                                  : $signed({2'b00, qu});
    assign pix_v = r_nv[PROJ_W-1] ? -$signed({2'b00, qv} + PROJ_W'(rv_nz))
                                  : $signed({2'b00, qv});
    assign in_view = !pix_u[PROJ_W-1] && (pix_u < $signed({16'd0, r_image_width}))
                  && !pix_v[PROJ_W-1] && (pix_v < $signed({16'd0, r_image_height}));

    always_comb begin
        if (r_dist > OBST_TH) begin
            cls_c = CLS_OBST;
        end else if (r_dist > YELLOW_TH) begin
            cls_c = CLS_GRAY;
        end else if (r_dist > GROUND_TH) begin
            cls_c = CLS_YELLOW;
        end else begin
            cls_c = CLS_GROUND;
        end
    end

    assign ax = r_x[15] ? 16'(-r_x) : r_x;

    ocls_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == S_CLS) && in_view && (cls_c == CLS_OBST)),
        .i_z     (r_z[12:0]),
        .i_ax    (ax),
        .o_done  (cor_done),
        .o_deg   (cor_deg)
    );

    assign ang_c = r_x[15] ? -$signed({1'b0, cor_deg}) : $signed({1'b0, cor_deg});

    assign bidx_r = 11'(r_bang) + 11'(ANGLE_BINS / 2);
    assign bidx_p = 11'(ang_c) + 11'(ANGLE_BINS / 2);
    assign bidx_r_ok = !bidx_r[10] && (bidx_r < 11'(ANGLE_BINS));
    assign bidx_p_ok = !bidx_p[10] && (bidx_p < 11'(ANGLE_BINS));

    // Keep the nearer depth: write when the bin is empty or the point is closer.
    assign ram_we = (r_state == S_WCMP) && (!r_flags[r_idx] || (r_z[12:0] < ram_rdata));

    ocls_ram #(
        .W     (13),
        .DEPTH (ANGLE_BINS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (r_z[12:0]),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_flags        <= '0;
            r_o_valid      <= 1'b0;
            r_mcnt         <= '0;
            r_plane_a      <= '0;
            r_plane_b      <= '0;
            r_plane_c      <= '0;
            r_plane_offset <= '0;
            r_depth_min    <= 13'd200;
            r_depth_max    <= 13'd5000;
            r_image_width  <= 12'd1280;
            r_image_height <= 12'd720;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_PLANE_A:  r_plane_a      <= i_cfg_data;
                    REG_PLANE_B:  r_plane_b      <= i_cfg_data;
                    REG_PLANE_C:  r_plane_c      <= i_cfg_data;
                    REG_OFFSET:   r_plane_offset <= i_cfg_data;
                    REG_DEPTH_LO: r_depth_min    <= i_cfg_data[12:0];
                    REG_DEPTH_HI: r_depth_max    <= i_cfg_data[12:0];
                    REG_WIDTH:    r_image_width  <= i_cfg_data[11:0];
                    REG_HEIGHT:   r_image_height <= i_cfg_data[11:0];
                    default: ;
                endcase
            end

            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_pv       <= i_point_valid;
                        r_x        <= i_point_x;
                        r_y        <= i_point_y;
                        r_z        <= i_point_z;
                        r_bang     <= i_bin_angle;
                        r_res_view <= 1'b0;
                        r_res_u    <= '0;
                        r_res_v    <= '0;
                        r_res_cls  <= CLS_NONE;
                        r_res_ang  <= '0;
                        r_res_occ  <= 1'b0;
                        r_res_min  <= '0;
                        r_state    <= i_cmd ? S_RCHK : S_PREP;
                    end
                end
                S_PREP: begin
                    r_nu    <= nu_c;
                    r_nv    <= nv_c;
                    r_state <= drop ? S_FIN : S_DSTRT;
                end
                S_DSTRT: begin
                    r_mcnt  <= '0;
                    r_dist  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_mcnt != 3'd4) begin
                        r_dist <= r_dist + addend;
                        r_mcnt <= r_mcnt + 3'd1;
                    end
                    if (du_done && dv_done) begin
                        r_state <= S_CLS;
                    end
                end
                S_CLS: begin
                    if (!in_view) begin
                        r_state <= S_FIN;
                    end else begin
                        r_res_view <= 1'b1;
                        r_res_u    <= pix_u[11:0];
                        r_res_v    <= pix_v[11:0];
                        r_res_cls  <= cls_c;
                        r_state    <= (cls_c == CLS_OBST) ? S_COR : S_FIN;
                    end
                end
                S_COR: begin
                    if (cor_done) begin
                        r_res_ang <= ang_c;
                        r_idx     <= bidx_p[AW-1:0];
                        r_state   <= bidx_p_ok ? S_WRD : S_FIN;
                    end
                end
                S_WRD: begin
                    r_state <= S_WCMP;
                end
                S_WCMP: begin
                    r_flags[r_idx] <= 1'b1;
                    r_state        <= S_FIN;
                end
                S_RCHK: begin
                    r_idx   <= bidx_r[AW-1:0];
                    r_state <= bidx_r_ok ? S_RRD : S_FIN;
                end
                S_RRD: begin
                    r_state <= r_flags[r_idx] ? S_ROUT : S_FIN;
                end
                S_ROUT: begin
                    r_res_occ      <= 1'b1;
                    r_res_min      <= ram_rdata;
                    r_flags[r_idx] <= 1'b0;
                    r_state        <= S_FIN;
                end
                S_FIN: begin
                    if (load_out) begin
                        r_o_view  <= r_res_view;
                        r_o_u     <= r_res_u;
                        r_o_v     <= r_res_v;
                        r_o_cls   <= r_res_cls;
                        r_o_ang   <= r_res_ang;
                        r_o_occ   <= r_res_occ;
                        r_o_min   <= r_res_min;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_o_valid;
    assign o_pixel_in_view  = r_o_view;
    assign o_pixel_u        = r_o_u;
    assign o_pixel_v        = r_o_v;
    assign o_point_class    = r_o_cls;
    assign o_obstacle_angle = r_o_ang;
    assign o_bin_occupied   = r_o_occ;
    assign o_bin_min_depth  = r_o_min;

    // A read that returns a bin leaves that bin empty.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUT) |=> !r_flags[$past(r_idx)])
        else $error("bin flag not cleared after read");

    // Only obstacle points carry a bearing.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_point_class != CLS_OBST)) |-> (o_obstacle_angle == 8'sd0))
        else $error("bearing on a non-obstacle result");

    // A point out of view carries no class.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_pixel_in_view) |-> (o_point_class == CLS_NONE))
        else $error("class on an out-of-view result");

    // Bin contents and point results never share one word.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bin_occupied) |-> (!o_pixel_in_view && (o_point_class == CLS_NONE)))
        else $error("bin read mixed with point result");
endmodule
